// ===== hw/rtl/i4to6x_pkg.sv =====
package i4to6x_pkg;

    // Configuration register indexes.
    localparam logic CFG_IPV6_OUT_MTU = 1'b0;
    localparam logic CFG_IPV4_OUT_MTU = 1'b1;

    // ICMPv4 message types handled by the translator.
    localparam logic [7:0] ICMP4_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] ICMP4_DEST_UNREACH = 8'd3;
    localparam logic [7:0] ICMP4_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP4_TIME_EXCEED  = 8'd11;
    localparam logic [7:0] ICMP4_PARAM_PROB   = 8'd12;

    // ICMPv4 destination unreachable codes with special handling.
    localparam logic [7:0] UNREACH_PROTOCOL  = 8'd2;
    localparam logic [7:0] UNREACH_PORT      = 8'd3;
    localparam logic [7:0] UNREACH_FRAG_NEED = 8'd4;

    // ICMPv6 message types.
    localparam logic [7:0] ICMP6_DEST_UNREACH  = 8'd1;
    localparam logic [7:0] ICMP6_PKT_TOO_BIG   = 8'd2;
    localparam logic [7:0] ICMP6_TIME_EXCEED   = 8'd3;
    localparam logic [7:0] ICMP6_PARAM_PROB    = 8'd4;
    localparam logic [7:0] ICMP6_ECHO_REQUEST  = 8'd128;
    localparam logic [7:0] ICMP6_ECHO_REPLY    = 8'd129;

    // How the rest-of-header word is finished in the later stages.
    typedef enum logic {
        REST_FIXED,
        REST_MTU
    } rest_sel_t;

    // Result of the header classification stage.
    typedef struct packed {
        logic        ok;
        logic        is_err;
        rest_sel_t   sel;
        logic [7:0]  v6_type;
        logic [7:0]  v6_code;
        logic [31:0] rest;
        logic [15:0] plateau;
    } xlat_s1_t;

    // Stage after the first MTU clamp steps.
    typedef struct packed {
        logic        ok;
        logic        is_err;
        rest_sel_t   sel;
        logic [7:0]  v6_type;
        logic [7:0]  v6_code;
        logic [31:0] rest;
        logic [16:0] mtu;
    } xlat_s2_t;

endpackage

// ===== hw/rtl/i4to6x_classify.sv =====
module i4to6x_classify
(
    input  logic [7:0]             v4_type,
    input  logic [7:0]             v4_code,
    input  logic [31:0]            v4_rest,
    input  logic                   inner_present,
    input  logic [15:0]            inner_total_len,
    output i4to6x_pkg::xlat_s1_t   info
);

    // RFC 1191 plateau table, largest first.
    localparam int PLATEAU_COUNT = 11;
    localparam logic [15:0] DEFAULT_PLATEAU = 16'd68;
    localparam logic [15:0] PLATEAU [PLATEAU_COUNT] = '{
        16'd65535, 16'd32000, 16'd17914, 16'd8166, 16'd4352, 16'd2002,
        16'd1492, 16'd1006, 16'd508, 16'd296, 16'd68
    };

    logic        tc_ok;
    logic        rest_ok;
    logic        ptr_ok;
    logic        echo;
    logic [7:0]  nt;
    logic [7:0]  nc;
    logic [7:0]  np;
    logic [31:0] rest_val;
    logic [15:0] plateau;
    i4to6x_pkg::rest_sel_t sel;

    // Type and code mapping.
    always_comb
    begin
        tc_ok = 1'b1;
        nt    = 8'd0;
        nc    = 8'd0;
        case (v4_type)
            i4to6x_pkg::ICMP4_ECHO_REQUEST:
            begin
                tc_ok = (v4_code == 8'd0);
                nt    = i4to6x_pkg::ICMP6_ECHO_REQUEST;
            end
            i4to6x_pkg::ICMP4_ECHO_REPLY:
            begin
                tc_ok = (v4_code == 8'd0);
                nt    = i4to6x_pkg::ICMP6_ECHO_REPLY;
            end
            i4to6x_pkg::ICMP4_DEST_UNREACH:
            begin
                if (v4_code inside {8'd0, 8'd1, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12})
                begin
                    nt = i4to6x_pkg::ICMP6_DEST_UNREACH;
                end
                else if (v4_code inside {8'd9, 8'd10, 8'd13, 8'd15})
                begin
                    nt = i4to6x_pkg::ICMP6_DEST_UNREACH;
                    nc = 8'd1;
                end
                else if (v4_code == i4to6x_pkg::UNREACH_PROTOCOL)
                begin
                    nt = i4to6x_pkg::ICMP6_PARAM_PROB;
                    nc = 8'd1;
                end
                else if (v4_code == i4to6x_pkg::UNREACH_PORT)
                begin
                    nt = i4to6x_pkg::ICMP6_DEST_UNREACH;
                    nc = 8'd4;
                end
                else if (v4_code == i4to6x_pkg::UNREACH_FRAG_NEED)
                begin
                    nt = i4to6x_pkg::ICMP6_PKT_TOO_BIG;
                end
                else
                begin
                    tc_ok = 1'b0;
                end
            end
            i4to6x_pkg::ICMP4_TIME_EXCEED:
            begin
                tc_ok = (v4_code inside {8'd0, 8'd1});
                nt    = i4to6x_pkg::ICMP6_TIME_EXCEED;
                nc    = v4_code;
            end
            i4to6x_pkg::ICMP4_PARAM_PROB:
            begin
                tc_ok = (v4_code inside {8'd0, 8'd2});
                nt    = i4to6x_pkg::ICMP6_PARAM_PROB;
            end
            default:
            begin
                tc_ok = 1'b0;
            end
        endcase
    end

    // Parameter-problem pointer remapping.
    always_comb
    begin
        ptr_ok = 1'b1;
        np     = 8'd0;
        if (v4_rest[31:24] inside {[8'd0:8'd1]})
            np = v4_rest[31:24];
        else if (v4_rest[31:24] inside {[8'd2:8'd3]})
            np = 8'd4;
        else if (v4_rest[31:24] == 8'd8)
            np = 8'd7;
        else if (v4_rest[31:24] == 8'd9)
            np = 8'd6;
        else if (v4_rest[31:24] inside {[8'd12:8'd15]})
            np = 8'd8;
        else if (v4_rest[31:24] inside {[8'd16:8'd19]})
            np = 8'd24;
        else
            ptr_ok = 1'b0;
    end

    // Plateau estimate: the first table entry below the inner total length wins.
    always_comb
    begin
        plateau = DEFAULT_PLATEAU;
        for (int i = PLATEAU_COUNT - 1; i >= 0; i--)
        begin
            if (PLATEAU[i] < inner_total_len)
                plateau = PLATEAU[i];
        end
        if (!inner_present)
            plateau = DEFAULT_PLATEAU;
    end

    // Rest-of-header checks and the fixed translated words.
    always_comb
    begin
        echo     = (v4_type == i4to6x_pkg::ICMP4_ECHO_REPLY) ||
                   (v4_type == i4to6x_pkg::ICMP4_ECHO_REQUEST);
        sel      = i4to6x_pkg::REST_FIXED;
        rest_val = 32'd0;
        if (echo)
        begin
            rest_ok  = 1'b1;
            rest_val = v4_rest;
        end
        else if (v4_type == i4to6x_pkg::ICMP4_DEST_UNREACH &&
                 v4_code == i4to6x_pkg::UNREACH_PROTOCOL)
        begin
            rest_ok  = (v4_rest == 32'd0);
            rest_val = 32'd6;
        end
        else if (v4_type == i4to6x_pkg::ICMP4_DEST_UNREACH &&
                 v4_code == i4to6x_pkg::UNREACH_FRAG_NEED)
        begin
            rest_ok  = (v4_rest[31:16] == 16'd0);
            rest_val = v4_rest;
            sel      = i4to6x_pkg::REST_MTU;
        end
        else if (v4_type == i4to6x_pkg::ICMP4_PARAM_PROB)
        begin
            rest_ok  = (v4_rest[23:0] == 24'd0) && ptr_ok;
            rest_val = {24'd0, np};
        end
        else
        begin
            rest_ok  = (v4_rest == 32'd0);
        end
    end

    // A rejected header carries all-zero fields apart from the plateau estimate.
    always_comb
    begin
        info.ok      = tc_ok && rest_ok;
        info.is_err  = info.ok && !echo;
        info.sel     = info.ok ? sel : i4to6x_pkg::REST_FIXED;
        info.v6_type = info.ok ? nt : 8'd0;
        info.v6_code = info.ok ? nc : 8'd0;
        info.rest    = info.ok ? rest_val : 32'd0;
        info.plateau = plateau;
    end

endmodule

// ===== hw/rtl/icmpv4_to_icmpv6_header_xlat_unit.sv =====
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   v4_type, v4_code, v4_rest, inner_total_len  inner_present
// m_axis    out  v6_type, v6_code, v6_rest                   accept, is_error_msg
// cfg       in   cfg_index 0: ipv6_out_mtu, 1: ipv4_out_mtu  (write only)
//
// One header per cycle while the output is not stalled.
// The three stages are classification, the first MTU clamp steps, and the
// final clamp with output assembly; the output register is the last stage.
// Reset clears the stage valid bits and loads both MTU registers with 1500.
// A stall on the output stops only the stages that are full behind it.
module icmpv4_to_icmpv6_header_xlat_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // v4_type[7:0], v4_code[15:8], v4_rest[47:16],
                                        // inner_total_len[63:48]
    input  logic        s_axis_tuser,   // inner_present

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // v6_type[7:0], v6_code[15:8], v6_rest[47:16]
    output logic [1:0]  m_axis_tuser,   // accept[0], is_error_msg[1]

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [15:0] MTU_RESET  = 16'd1500;
    localparam logic [15:0] MTU_V4_MAX = 16'd65515;
    localparam logic [16:0] HDR_DELTA  = 17'd20;
    localparam logic [16:0] MTU_V6_MIN = 17'd1280;

    logic [15:0] ipv6_mtu_reg;
    logic [15:0] ipv4_mtu_reg;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic rdy1, rdy2, rdy3;

    i4to6x_pkg::xlat_s1_t s1_next, s1_reg;
    i4to6x_pkg::xlat_s2_t s2_next, s2_reg;
    logic [47:0] tdata_next, tdata_reg;
    logic [1:0]  tuser_next, tuser_reg;

    logic [15:0] mtu_base;
    logic [15:0] mtu_capped;
    logic [16:0] mtu_plus;
    logic [16:0] v4_cap;
    logic [16:0] mtu_v4;
    logic [16:0] mtu_final;
    logic [31:0] rest_out;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv6_mtu_reg <= MTU_RESET;
            ipv4_mtu_reg <= MTU_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i4to6x_pkg::CFG_IPV6_OUT_MTU: ipv6_mtu_reg <= cfg_data;
                i4to6x_pkg::CFG_IPV4_OUT_MTU: ipv4_mtu_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage readiness: a stage moves when it is empty or the next one moves.
    assign rdy3          = !v3_reg || m_axis_tready;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_comb
    begin
        v1_next = rdy1 ? s_axis_tvalid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage 1: type, code, rest checks, pointer map and plateau estimate.
    i4to6x_classify u_classify
    (
        .v4_type         (s_axis_tdata[7:0]),
        .v4_code         (s_axis_tdata[15:8]),
        .v4_rest         (s_axis_tdata[47:16]),
        .inner_present   (s_axis_tuser),
        .inner_total_len (s_axis_tdata[63:48]),
        .info            (s1_next)
    );

    // Stage 2: zero-MTU substitution, IPv4 cap, header delta and IPv6 cap.
    always_comb
    begin
        mtu_base   = (s1_reg.rest[15:0] == 16'd0) ? s1_reg.plateau : s1_reg.rest[15:0];
        mtu_capped = (mtu_base > MTU_V4_MAX) ? MTU_V4_MAX : mtu_base;
        mtu_plus   = {1'b0, mtu_capped} + HDR_DELTA;
        s2_next.ok      = s1_reg.ok;
        s2_next.is_err  = s1_reg.is_err;
        s2_next.sel     = s1_reg.sel;
        s2_next.v6_type = s1_reg.v6_type;
        s2_next.v6_code = s1_reg.v6_code;
        s2_next.rest    = s1_reg.rest;
        s2_next.mtu     = (mtu_plus > {1'b0, ipv6_mtu_reg}) ? {1'b0, ipv6_mtu_reg} : mtu_plus;
    end

    // Stage 3: outbound IPv4 cap, IPv6 minimum and output assembly.
    always_comb
    begin
        v4_cap    = {1'b0, ipv4_mtu_reg} + HDR_DELTA;
        mtu_v4    = (s2_reg.mtu > v4_cap) ? v4_cap : s2_reg.mtu;
        mtu_final = (mtu_v4 < MTU_V6_MIN) ? MTU_V6_MIN : mtu_v4;
        rest_out  = (s2_reg.sel == i4to6x_pkg::REST_MTU) ? {16'd0, mtu_final[15:0]}
                                                         : s2_reg.rest;
        tdata_next = {rest_out, s2_reg.v6_code, s2_reg.v6_type};
        tuser_next = {s2_reg.is_err, s2_reg.ok};
    end

    // Stage payload registers, loaded as their valid bits advance.
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
        if (rdy3 && v2_reg)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

    // A rejected header leaves every other field at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 48'd0 && !m_axis_tuser[1])
        else $error("rejected beat carries nonzero fields");

    // Accepted informational messages are echo request or reply.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1] |->
        m_axis_tdata[7:0] == i4to6x_pkg::ICMP6_ECHO_REQUEST ||
        m_axis_tdata[7:0] == i4to6x_pkg::ICMP6_ECHO_REPLY)
        else $error("non-error beat is not an echo");

    // A translated MTU never falls below the IPv6 minimum.
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && rdy3 && s2_reg.ok && s2_reg.sel == i4to6x_pkg::REST_MTU |=>
        m_axis_tdata[47:16] >= {15'd0, MTU_V6_MIN})
        else $error("translated MTU below 1280");

    // Input back-pressure only when every stage is full and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> v1_reg && v2_reg && v3_reg && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== sim/tb_icmpv4_to_icmpv6_header_xlat_unit.sv =====
`timescale 1ns / 100ps

module tb_icmpv4_to_icmpv6_header_xlat_unit;

    // One ICMPv4 header as offered on the input stream.
    typedef struct packed {
        logic [7:0]  v4_type;
        logic [7:0]  v4_code;
        logic [31:0] v4_rest;
        logic        inner_present;
        logic [15:0] inner_total_len;
    } hdr_item_t;

    // One translated ICMPv6 header as seen on the output stream.
    typedef struct packed {
        logic        accept;
        logic [7:0]  v6_type;
        logic [7:0]  v6_code;
        logic [31:0] v6_rest;
        logic        is_error_msg;
    } v6_hdr_t;

    localparam int unsigned MTU_FLOOR     = 1280;
    localparam int unsigned MTU_CEIL_V4   = 65515;
    localparam int unsigned IPV4_HDR_GROW = 20;
    localparam int unsigned MTU_DEFAULT   = 68;
    localparam int unsigned LONG_HOLD_AT  = 300;
    localparam int unsigned LONG_HOLD_LEN = 80;
    localparam int unsigned PHASE_ITEMS   = 190;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // v4_type, v4_code, v4_rest, inner_total_len
    logic        s_axis_tuser = 1'b0; // inner_present

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // v6_type, v6_code, v6_rest
    logic [1:0]  m_axis_tuser;        // accept, is_error_msg

    logic        cfg_we = 1'b0;
    logic        cfg_index = i4to6x_pkg::CFG_IPV6_OUT_MTU;
    logic [15:0] cfg_data = '0;

    // Plateau table used when a fragmentation-needed message carries no MTU.
    int unsigned plateau_tab [0:10] = '{65535, 32000, 17914, 8166, 4352, 2002,
                                        1492, 1006, 508, 296, 68};

    // Shadow copy of the MTU registers.
    logic [15:0] mtu6_cfg = 16'd1500;
    logic [15:0] mtu4_cfg = 16'd1500;

    hdr_item_t   pending_hdrs [$];
    v6_hdr_t     due_results [$];

    logic        in_taken = 1'b0;
    logic        idle_en = 1'b1;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_cnt = 0;
    logic        long_hold_done = 1'b0;
    int unsigned rx_count = 0;
    int unsigned translated_count = 0;
    int unsigned dropped_count = 0;
    int unsigned fail_count = 0;
    int unsigned mtu_settings = 1;

    icmpv4_to_icmpv6_header_xlat_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Translate one ICMPv4 header into the ICMPv6 header the block should produce.
    function automatic v6_hdr_t translate_header(hdr_item_t h);
        v6_hdr_t     r;
        logic        ok;
        logic        echo;
        logic [7:0]  nt;
        logic [7:0]  nc;
        logic [31:0] nrest;
        int unsigned mtu;
        r = '0;
        ok = 1'b1;
        nt = '0;
        nc = '0;
        nrest = '0;
        echo = (h.v4_type == i4to6x_pkg::ICMP4_ECHO_REPLY) ||
               (h.v4_type == i4to6x_pkg::ICMP4_ECHO_REQUEST);
        case (h.v4_type)
            i4to6x_pkg::ICMP4_ECHO_REQUEST:
            begin
                ok = (h.v4_code == 8'd0);
                nt = i4to6x_pkg::ICMP6_ECHO_REQUEST;
                nrest = h.v4_rest;
            end
            i4to6x_pkg::ICMP4_ECHO_REPLY:
            begin
                ok = (h.v4_code == 8'd0);
                nt = i4to6x_pkg::ICMP6_ECHO_REPLY;
                nrest = h.v4_rest;
            end
            i4to6x_pkg::ICMP4_DEST_UNREACH:
            begin
                ok = (h.v4_rest == 32'd0);
                case (h.v4_code)
                    // Network, host, source-route and unknown/isolated codes.
                    8'd0, 8'd1, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12:
                        nt = i4to6x_pkg::ICMP6_DEST_UNREACH;
                    // Administratively prohibited codes.
                    8'd9, 8'd10, 8'd13, 8'd15:
                    begin
                        nt = i4to6x_pkg::ICMP6_DEST_UNREACH;
                        nc = 8'd1;
                    end
                    i4to6x_pkg::UNREACH_PROTOCOL:
                    begin
                        nt = i4to6x_pkg::ICMP6_PARAM_PROB;
                        nc = 8'd1;
                        nrest = 32'd6;
                    end
                    i4to6x_pkg::UNREACH_PORT:
                    begin
                        nt = i4to6x_pkg::ICMP6_DEST_UNREACH;
                        nc = 8'd4;
                    end
                    i4to6x_pkg::UNREACH_FRAG_NEED:
                    begin
                        // The upper two bytes must be clear; the MTU is re-estimated
                        // when zero and then clamped against both links.
                        ok = (h.v4_rest[31:16] == 16'd0);
                        nt = i4to6x_pkg::ICMP6_PKT_TOO_BIG;
                        mtu = {16'd0, h.v4_rest[15:0]};
                        if (mtu == 0)
                        begin
                            mtu = MTU_DEFAULT;
                            if (h.inner_present)
                            begin
                                for (int i = 10; i >= 0; i--)
                                begin
                                    if (plateau_tab[i] < h.inner_total_len)
                                        mtu = plateau_tab[i];
                                end
                            end
                        end
                        if (mtu > MTU_CEIL_V4)
                            mtu = MTU_CEIL_V4;
                        mtu = mtu + IPV4_HDR_GROW;
                        if (mtu > mtu6_cfg)
                            mtu = mtu6_cfg;
                        if (mtu > mtu4_cfg + IPV4_HDR_GROW)
                            mtu = mtu4_cfg + IPV4_HDR_GROW;
                        if (mtu < MTU_FLOOR)
                            mtu = MTU_FLOOR;
                        nrest = mtu & 32'h0000_FFFF;
                    end
                    default:
                        ok = 1'b0;
                endcase
            end
            i4to6x_pkg::ICMP4_TIME_EXCEED:
            begin
                ok = (h.v4_code <= 8'd1) && (h.v4_rest == 32'd0);
                nt = i4to6x_pkg::ICMP6_TIME_EXCEED;
                nc = h.v4_code;
            end
            i4to6x_pkg::ICMP4_PARAM_PROB:
            begin
                ok = ((h.v4_code == 8'd0) || (h.v4_code == 8'd2))
                     && (h.v4_rest[23:0] == 24'd0);
                nt = i4to6x_pkg::ICMP6_PARAM_PROB;
                // The pointer moves from the IPv4 header layout to the IPv6 one.
                case (h.v4_rest[31:24])
                    8'd0, 8'd1:                 nrest = {24'd0, h.v4_rest[31:24]};
                    8'd2, 8'd3:                 nrest = 32'd4;
                    8'd8:                       nrest = 32'd7;
                    8'd9:                       nrest = 32'd6;
                    8'd12, 8'd13, 8'd14, 8'd15: nrest = 32'd8;
                    8'd16, 8'd17, 8'd18, 8'd19: nrest = 32'd24;
                    default:                    ok = 1'b0;
                endcase
            end
            default:
                ok = 1'b0;
        endcase
        if (ok)
        begin
            r.accept = 1'b1;
            r.v6_type = nt;
            r.v6_code = nc;
            r.v6_rest = nrest;
            r.is_error_msg = !echo;
        end
        return r;
    endfunction

    // Random header: mostly well-formed messages with random content, some noise.
    function automatic hdr_item_t random_header();
        hdr_item_t   h;
        int unsigned len_pick;
        int unsigned kind;
        int unsigned mtu_pick;
        h.v4_type = 8'($urandom);
        h.v4_code = 8'($urandom);
        h.v4_rest = $urandom;
        h.inner_present = 1'($urandom_range(0, 1));
        len_pick = $urandom_range(0, 5);
        if (len_pick == 0)
            h.inner_total_len = 16'(plateau_tab[$urandom_range(0, 10)]
                                    + $urandom_range(0, 2) - 1);
        else if (len_pick == 1)
            h.inner_total_len = 16'($urandom_range(0, 100));
        else if (len_pick == 2)
            h.inner_total_len = 16'hFFFF;
        else
            h.inner_total_len = 16'($urandom);
        kind = $urandom_range(0, 9);
        case (kind)
            0:
            begin
                h.v4_type = ($urandom_range(0, 1) == 0) ? i4to6x_pkg::ICMP4_ECHO_REQUEST
                                                         : i4to6x_pkg::ICMP4_ECHO_REPLY;
                if ($urandom_range(0, 7) != 0)
                    h.v4_code = 8'd0;
            end
            1, 2:
            begin
                h.v4_type = i4to6x_pkg::ICMP4_DEST_UNREACH;
                h.v4_code = 8'($urandom_range(0, 16));
                if ($urandom_range(0, 7) != 0)
                    h.v4_rest = 32'd0;
            end
            3, 4, 5:
            begin
                h.v4_type = i4to6x_pkg::ICMP4_DEST_UNREACH;
                h.v4_code = i4to6x_pkg::UNREACH_FRAG_NEED;
                mtu_pick = $urandom_range(0, 5);
                if (mtu_pick <= 1)
                    h.v4_rest[15:0] = 16'd0;
                else if (mtu_pick == 2)
                    h.v4_rest[15:0] = 16'($urandom_range(1200, 1600));
                else if (mtu_pick == 3)
                    h.v4_rest[15:0] = 16'($urandom_range(65500, 65535));
                else if (mtu_pick == 4)
                    h.v4_rest[15:0] = 16'($urandom_range(1, 100));
                if ($urandom_range(0, 7) != 0)
                    h.v4_rest[31:16] = 16'd0;
            end
            6:
            begin
                h.v4_type = i4to6x_pkg::ICMP4_TIME_EXCEED;
                h.v4_code = 8'($urandom_range(0, 2));
                if ($urandom_range(0, 7) != 0)
                    h.v4_rest = 32'd0;
            end
            7:
            begin
                h.v4_type = i4to6x_pkg::ICMP4_PARAM_PROB;
                h.v4_code = 8'($urandom_range(0, 2));
                if ($urandom_range(0, 7) != 0)
                    h.v4_rest = {8'($urandom_range(0, 21)), 24'd0};
            end
            default:
            begin
                // Fully random header.
            end
        endcase
        return h;
    endfunction

    task automatic queue_hdr(input logic [7:0] t, input logic [7:0] c,
                             input logic [31:0] rest, input logic present,
                             input logic [15:0] len);
        hdr_item_t h;
        h.v4_type = t;
        h.v4_code = c;
        h.v4_rest = rest;
        h.inner_present = present;
        h.inner_total_len = len;
        pending_hdrs.push_back(h);
    endtask

    task automatic queue_random(input int unsigned count);
        repeat (count)
            pending_hdrs.push_back(random_header());
    endtask

    // Wait until every queued header has gone in and every result has come out.
    task automatic wait_drained(input int unsigned settle);
        while (pending_hdrs.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write both MTU registers while the block is idle.
    task automatic set_mtus(input logic [15:0] v6_mtu, input logic [15:0] v4_mtu);
        wait_drained(4);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= i4to6x_pkg::CFG_IPV6_OUT_MTU;
        cfg_data <= v6_mtu;
        @(negedge clk);
        cfg_index <= i4to6x_pkg::CFG_IPV4_OUT_MTU;
        cfg_data <= v4_mtu;
        @(negedge clk);
        cfg_we <= 1'b0;
        mtu_settings++;
    endtask

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("icmpv4_to_icmpv6_header_xlat_unit regression: fail");
        $finish;
    end

    // Input driver: holds a beat until it is taken, with random idle bursts.
    always @(negedge clk)
    begin : hdr_driver
        hdr_item_t nxt;
        logic      v;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            v = 1'b0;
            if (tx_gap > 0)
                tx_gap--;
            else if (idle_en && $urandom_range(0, 9) == 0)
                tx_gap = $urandom_range(0, 3);
            else if (pending_hdrs.size() > 0)
            begin
                nxt = pending_hdrs.pop_front();
                v = 1'b1;
                s_axis_tdata <= {nxt.inner_total_len, nxt.v4_rest, nxt.v4_code, nxt.v4_type};
                s_axis_tuser <= nxt.inner_present;
            end
            s_axis_tvalid <= v;
        end
    end

    // Output ready: random stall bursts plus one long hold-off to back up the pipe.
    always @(negedge clk)
    begin : result_ready
        logic r;
        r = 1'b0;
        if (rst_n)
        begin
            if (hold_cnt > 0)
                hold_cnt--;
            else if (rx_count >= LONG_HOLD_AT && !long_hold_done)
            begin
                hold_cnt = LONG_HOLD_LEN - 1;
                long_hold_done = 1'b1;
            end
            else if (rx_gap > 0)
                rx_gap--;
            else if (idle_en && $urandom_range(0, 9) == 0)
                rx_gap = $urandom_range(0, 3);
            else
                r = 1'b1;
        end
        m_axis_tready <= r;
    end

    // Monitor: predicts on each input beat and checks each output beat.
    always @(posedge clk or negedge rst_n)
    begin : xlat_monitor
        hdr_item_t seen;
        v6_hdr_t   want;
        v6_hdr_t   got;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;

            if (cfg_we)
            begin
                if (cfg_index == i4to6x_pkg::CFG_IPV6_OUT_MTU)
                    mtu6_cfg <= cfg_data;
                else
                    mtu4_cfg <= cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.v4_type = s_axis_tdata[7:0];
                seen.v4_code = s_axis_tdata[15:8];
                seen.v4_rest = s_axis_tdata[47:16];
                seen.inner_total_len = s_axis_tdata[63:48];
                seen.inner_present = s_axis_tuser;
                due_results.push_back(translate_header(seen));
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.v6_type = m_axis_tdata[7:0];
                got.v6_code = m_axis_tdata[15:8];
                got.v6_rest = m_axis_tdata[47:16];
                got.accept = m_axis_tuser[0];
                got.is_error_msg = m_axis_tuser[1];
                rx_count++;
                if (due_results.size() == 0)
                begin
                    $error("output beat with no header outstanding: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.accept)
                        translated_count++;
                    else
                        dropped_count++;
                    if (got.accept !== want.accept)
                    begin
                        $error("accept: expected %0b, got %0b", want.accept, got.accept);
                        fail_count++;
                    end
                    if (got.v6_type !== want.v6_type)
                    begin
                        $error("v6_type: expected %0d, got %0d", want.v6_type, got.v6_type);
                        fail_count++;
                    end
                    if (got.v6_code !== want.v6_code)
                    begin
                        $error("v6_code: expected %0d, got %0d", want.v6_code, got.v6_code);
                        fail_count++;
                    end
                    if (got.v6_rest !== want.v6_rest)
                    begin
                        $error("v6_rest: expected %h, got %h", want.v6_rest, got.v6_rest);
                        fail_count++;
                    end
                    if (got.is_error_msg !== want.is_error_msg)
                    begin
                        $error("is_error_msg: expected %0b, got %0b",
                               want.is_error_msg, got.is_error_msg);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed headers under the reset MTU values.
        queue_hdr(i4to6x_pkg::ICMP4_ECHO_REQUEST, 8'd0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        queue_hdr(i4to6x_pkg::ICMP4_ECHO_REPLY, 8'd0, 32'h0000_0000, 1'b0, 16'h0000);
        queue_hdr(i4to6x_pkg::ICMP4_ECHO_REQUEST, 8'hFF, 32'h1234_5678, 1'b0, 16'd0);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, 8'd0, 32'd0, 1'b1, 16'd60);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, 8'd15, 32'd0, 1'b1, 16'd60);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_PROTOCOL,
                  32'd0, 1'b1, 16'd60);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_PROTOCOL,
                  32'h0000_0001, 1'b1, 16'd60);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_PORT,
                  32'd0, 1'b1, 16'd60);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, 8'd14, 32'd0, 1'b1, 16'd60);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, 8'd1, 32'h8000_0000, 1'b1, 16'd60);
        // Fragmentation needed: zero MTU via plateau or default, given MTUs, stray upper bytes.
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_FRAG_NEED,
                  32'd0, 1'b1, 16'hFFFF);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_FRAG_NEED,
                  32'd0, 1'b1, 16'd1493);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_FRAG_NEED,
                  32'd0, 1'b1, 16'd68);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_FRAG_NEED,
                  32'd0, 1'b0, 16'hFFFF);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_FRAG_NEED,
                  32'h0000_FFFF, 1'b1, 16'd0);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_FRAG_NEED,
                  32'h0000_0500, 1'b1, 16'd0);
        queue_hdr(i4to6x_pkg::ICMP4_DEST_UNREACH, i4to6x_pkg::UNREACH_FRAG_NEED,
                  32'h0001_0500, 1'b1, 16'd0);
        queue_hdr(i4to6x_pkg::ICMP4_TIME_EXCEED, 8'd0, 32'd0, 1'b1, 16'd40);
        queue_hdr(i4to6x_pkg::ICMP4_TIME_EXCEED, 8'd1, 32'd0, 1'b1, 16'd40);
        queue_hdr(i4to6x_pkg::ICMP4_TIME_EXCEED, 8'd2, 32'd0, 1'b1, 16'd40);
        queue_hdr(i4to6x_pkg::ICMP4_TIME_EXCEED, 8'd0, 32'h0000_0100, 1'b1, 16'd40);
        // Parameter problem: pointer remap, a rejected pointer, a rejected code and stray bytes.
        queue_hdr(i4to6x_pkg::ICMP4_PARAM_PROB, 8'd0, 32'h0900_0000, 1'b1, 16'd40);
        queue_hdr(i4to6x_pkg::ICMP4_PARAM_PROB, 8'd2, 32'h1300_0000, 1'b1, 16'd40);
        queue_hdr(i4to6x_pkg::ICMP4_PARAM_PROB, 8'd0, 32'h1400_0000, 1'b1, 16'd40);
        queue_hdr(i4to6x_pkg::ICMP4_PARAM_PROB, 8'd1, 32'h0000_0000, 1'b1, 16'd40);
        queue_hdr(i4to6x_pkg::ICMP4_PARAM_PROB, 8'd0, 32'h0000_0001, 1'b1, 16'd40);
        queue_hdr(8'hFF, 8'd0, 32'd0, 1'b1, 16'd40);

        // Random phases under several MTU settings, extremes included.
        set_mtus(16'd65535, 16'd65515);
        queue_random(PHASE_ITEMS);
        set_mtus(16'd1280, 16'd68);
        queue_random(PHASE_ITEMS);
        set_mtus(16'd1280, 16'd65515);
        queue_random(PHASE_ITEMS);
        set_mtus(16'd65535, 16'd68);
        queue_random(PHASE_ITEMS);
        set_mtus(16'($urandom_range(1280, 65535)), 16'($urandom_range(68, 65515)));
        queue_random(PHASE_ITEMS);
        set_mtus(16'($urandom_range(1280, 2000)), 16'($urandom_range(1200, 2000)));
        queue_random(PHASE_ITEMS);

        // Final phase back-to-back with no idling on either side.
        set_mtus(16'd1500, 16'd1500);
        idle_en = 1'b0;
        queue_random(PHASE_ITEMS);

        wait_drained(8);
        $display("Checked %0d headers: %0d translated, %0d dropped, over %0d MTU settings.",
                 rx_count, translated_count, dropped_count, mtu_settings);
        $display("Included a long output hold-off and drained pauses between settings.");
        if (fail_count == 0)
            $display("icmpv4_to_icmpv6_header_xlat_unit regression: pass");
        else
            $display("icmpv4_to_icmpv6_header_xlat_unit regression: fail");
        $finish;
    end

endmodule
